/* hdl/tcw_pkg.sv */
// Shared definitions for the text console writer: default geometry, operation and
// character codes, cell constants and the cursor unit's command and status types.
// No dependencies; used by every file of the block.
package tcw_pkg;

	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	localparam int OP_W        = 2;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = 16;
	localparam int ADDR_IN_W   = 11;
	localparam int CURSOR_O_W  = 11;

	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h2F;
	localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, BLANK_CHAR};

	// Spaces written by a tab, less the first one.
	localparam logic [1:0] TAB_EXTRA = 2'd3;

	// Commands to the cursor unit.
	typedef logic [2:0] cur_uop_t;
	localparam cur_uop_t UOP_HOLD    = 3'd0;
	localparam cur_uop_t UOP_ADVANCE = 3'd1;
	localparam cur_uop_t UOP_BACK    = 3'd2;
	localparam cur_uop_t UOP_NEWLINE = 3'd3;
	localparam cur_uop_t UOP_UNSCROLL = 3'd4;
	localparam cur_uop_t UOP_CLEAR   = 3'd5;

	// Status of the current cursor, as the sequencer needs it.
	typedef struct packed {
		logic last_cell;  // advancing from here reaches the end of the store
		logic last_row;   // a newline from here reaches the end of the store
		logic at_zero;    // cursor is at the first cell
	} cur_flags_t;

endpackage

/* hdl/tcw_cursor.sv */
// Cursor unit of the text console writer: holds the linear cursor and its column,
// and applies one command a cycle (advance, back, newline, scroll correction, clear).
// Depends on tcw_pkg.
module tcw_cursor #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF,
	localparam int CELLS  = COLUMNS * ROWS,
	localparam int CUR_W  = $clog2(CELLS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::cur_uop_t  uop,
	output logic [CUR_W-1:0]   cursor,
	output tcw_pkg::cur_flags_t flags
);

	localparam int COL_W = $clog2(COLUMNS);

	logic [CUR_W-1:0] cursor_q;
	logic [COL_W-1:0] col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			col_q    <= '0;
		end else begin
			unique case (uop)
				tcw_pkg::UOP_ADVANCE: begin
					cursor_q <= cursor_q + CUR_W'(1);
					col_q    <= (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + COL_W'(1);
				end
				tcw_pkg::UOP_BACK: begin
					cursor_q <= cursor_q - CUR_W'(1);
					col_q    <= (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - COL_W'(1);
				end
				tcw_pkg::UOP_NEWLINE: begin
					cursor_q <= cursor_q - CUR_W'(col_q) + CUR_W'(COLUMNS);
					col_q    <= '0;
				end
				tcw_pkg::UOP_UNSCROLL: begin
					cursor_q <= cursor_q - CUR_W'(COLUMNS);
				end
				tcw_pkg::UOP_CLEAR: begin
					cursor_q <= '0;
					col_q    <= '0;
				end
				default: begin
					cursor_q <= cursor_q;
					col_q    <= col_q;
				end
			endcase
		end
	end

	assign cursor          = cursor_q;
	assign flags.last_cell = (cursor_q == CUR_W'(CELLS - 1));
	assign flags.last_row  = (cursor_q >= CUR_W'(CELLS - COLUMNS));
	assign flags.at_zero   = (cursor_q == '0);

endmodule

/* hdl/text_console_writer_core.sv */
// Text console writer: sequencer, cell store and result register of the block.
// Depends on tcw_pkg and instantiates tcw_cursor.
//
// Each command passes from the idle state through its own states to S_DONE, which
// raises done: S_PUT for a character or each tab space, S_NL for a newline, S_BS
// and S_BSW for a backspace (S_BS alone at cursor zero), S_READ for a read, S_CLR
// for a clear, none for the unused op. A scroll runs S_SCRL and then S_SEND, using
// the single write port of the store. A new transaction is taken only in the idle
// state; busy is high until done rises. After reset a clearing pass fills the store
// with blanks; busy stays high meanwhile, and attribute writes are taken as ever.
module text_console_writer_core #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration: attribute register, written whenever attribute_we is high.
	input  logic                                attribute_we,
	input  logic [tcw_pkg::ATTR_W-1:0]          attribute,
	// Command side.
	input  logic                                start,
	output logic                                busy,
	input  logic [tcw_pkg::OP_W-1:0]            op,
	input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
	input  logic [tcw_pkg::ADDR_IN_W-1:0]       cell_address,
	// Result side: valid for the single cycle in which done is high.
	output logic                                done,
	output logic [tcw_pkg::CURSOR_O_W-1:0]      cursor,
	output logic [tcw_pkg::CELL_W-1:0]          read_data,
	output logic                                scrolled
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CUR_W  = $clog2(CELLS + 1);
	localparam logic [ADDR_W-1:0] LAST_IDX       = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] LAST_ROW_START = ADDR_W'(CELLS - COLUMNS);

	// Sequencer states.
	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] S_INIT   = 4'd0;
	localparam logic [ST_W-1:0] S_IDLE   = 4'd1;
	localparam logic [ST_W-1:0] S_PUT    = 4'd2;
	localparam logic [ST_W-1:0] S_NL     = 4'd3;
	localparam logic [ST_W-1:0] S_BS     = 4'd4;
	localparam logic [ST_W-1:0] S_BSW    = 4'd5;
	localparam logic [ST_W-1:0] S_SCRL   = 4'd6;
	localparam logic [ST_W-1:0] S_SEND   = 4'd7;
	localparam logic [ST_W-1:0] S_CLR    = 4'd8;
	localparam logic [ST_W-1:0] S_READ   = 4'd9;
	localparam logic [ST_W-1:0] S_DONE   = 4'd10;

	logic [ST_W-1:0]               state_q;
	logic [tcw_pkg::ATTR_W-1:0]    attr_q;
	logic [tcw_pkg::CHAR_W-1:0]    ch_q;
	logic [1:0]                    tab_left_q;
	logic [ADDR_W-1:0]             idx_q;
	logic                          addr_ok_q;
	logic                          scroll_seen_q;
	logic [tcw_pkg::CELL_W-1:0]    read_val_q;

	// Cell store and its registered read port.
	logic [tcw_pkg::CELL_W-1:0]    mem_q [CELLS];
	logic [tcw_pkg::CELL_W-1:0]    rdata_q;
	logic                          mem_we;
	logic [ADDR_W-1:0]             mem_waddr;
	logic [tcw_pkg::CELL_W-1:0]    mem_wdata;
	logic [ADDR_W-1:0]             mem_raddr;

	// Write stage of the scroll copy: the cell read in the cycle before lands here.
	logic                          sc_we_s1;
	logic [ADDR_W-1:0]             sc_addr_s1;
	logic                          sc_blank_s1;

	// Result register.
	logic                          done_q;
	logic [tcw_pkg::CURSOR_O_W-1:0] cursor_out_q;
	logic [tcw_pkg::CELL_W-1:0]    read_data_q;
	logic                          scrolled_q;

	tcw_pkg::cur_uop_t             uop;
	tcw_pkg::cur_flags_t           cur_flags;
	logic [CUR_W-1:0]              cur_pos;
	logic [tcw_pkg::CELL_W-1:0]    blank;
	logic [ADDR_W-1:0]             src_addr;

	tcw_cursor #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.uop    (uop),
		.cursor (cur_pos),
		.flags  (cur_flags)
	);

	// A blank cell takes the attribute as it stands now; the pass after reset uses the reset blank.
	assign blank    = {attr_q, tcw_pkg::BLANK_CHAR};
	assign src_addr = idx_q + ADDR_W'(COLUMNS);

	// Cursor commands and store port selection for the current state.
	always_comb begin
		uop       = tcw_pkg::UOP_HOLD;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = blank;
		mem_raddr = ADDR_W'(cell_address);
		unique case (state_q)
			S_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = tcw_pkg::RESET_BLANK;
			end
			S_CLR: begin
				mem_we = 1'b1;
				uop    = tcw_pkg::UOP_CLEAR;
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cur_pos);
				mem_wdata = {attr_q, ch_q};
				uop       = tcw_pkg::UOP_ADVANCE;
			end
			S_NL: begin
				uop = tcw_pkg::UOP_NEWLINE;
			end
			S_BS: begin
				if (!cur_flags.at_zero) begin
					uop = tcw_pkg::UOP_BACK;
				end
			end
			S_BSW: begin
				mem_we    = 1'b1;
				mem_waddr = ADDR_W'(cur_pos);
			end
			S_SCRL: begin
				// The last row has no source: it is filled with blanks.
				mem_raddr = (idx_q >= LAST_ROW_START) ? '0 : src_addr;
			end
			S_SEND: begin
				uop = tcw_pkg::UOP_UNSCROLL;
			end
			default: begin
				uop = tcw_pkg::UOP_HOLD;
			end
		endcase
		// The copy write only ever runs in the scroll states, which write nothing else.
		if (sc_we_s1) begin
			mem_we    = 1'b1;
			mem_waddr = sc_addr_s1;
			mem_wdata = sc_blank_s1 ? blank : rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem_q[mem_raddr];
	end

	// Attribute register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcw_pkg::ATTR_RESET;
		end else if (attribute_we) begin
			attr_q <= attribute;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_INIT;
			idx_q         <= '0;
			tab_left_q    <= '0;
			scroll_seen_q <= 1'b0;
			sc_we_s1      <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			sc_we_s1 <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					idx_q <= idx_q + ADDR_W'(1);
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						scroll_seen_q <= 1'b0;
						read_val_q    <= '0;
						idx_q         <= '0;
						tab_left_q    <= '0;
						ch_q          <= char_code;
						addr_ok_q     <= (32'(cell_address) < 32'(CELLS));
						unique case (op)
							tcw_pkg::OP_WRITE: begin
								if (char_code == tcw_pkg::CH_NEWLINE) begin
									state_q <= S_NL;
								end else if (char_code == tcw_pkg::CH_TAB) begin
									ch_q       <= tcw_pkg::BLANK_CHAR;
									tab_left_q <= tcw_pkg::TAB_EXTRA;
									state_q    <= S_PUT;
								end else if (char_code == tcw_pkg::CH_BACKSPACE) begin
									state_q <= S_BS;
								end else begin
									state_q <= S_PUT;
								end
							end
							tcw_pkg::OP_CLEAR: begin
								state_q <= S_CLR;
							end
							tcw_pkg::OP_READ: begin
								state_q <= S_READ;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_PUT: begin
					if (cur_flags.last_cell) begin
						idx_q   <= '0;
						state_q <= S_SCRL;
					end else if (tab_left_q != '0) begin
						tab_left_q <= tab_left_q - 2'd1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_NL: begin
					if (cur_flags.last_row) begin
						idx_q   <= '0;
						state_q <= S_SCRL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_BS: begin
					state_q <= cur_flags.at_zero ? S_DONE : S_BSW;
				end
				S_BSW: begin
					state_q <= S_DONE;
				end
				S_SCRL: begin
					sc_we_s1    <= 1'b1;
					sc_addr_s1  <= idx_q;
					sc_blank_s1 <= (idx_q >= LAST_ROW_START);
					idx_q       <= idx_q + ADDR_W'(1);
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_SEND;
					end
				end
				S_SEND: begin
					scroll_seen_q <= 1'b1;
					if (tab_left_q != '0) begin
						tab_left_q <= tab_left_q - 2'd1;
						state_q    <= S_PUT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_CLR: begin
					idx_q <= idx_q + ADDR_W'(1);
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						state_q <= S_DONE;
					end
				end
				S_READ: begin
					// Out-of-range addresses return zero.
					read_val_q <= addr_ok_q ? rdata_q : '0;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					done_q       <= 1'b1;
					cursor_out_q <= tcw_pkg::CURSOR_O_W'(cur_pos);
					read_data_q  <= read_val_q;
					scrolled_q   <= scroll_seen_q;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign cursor    = cursor_out_q;
	assign read_data = read_data_q;
	assign scrolled  = scrolled_q;

endmodule

/* hdl/tcw_checker.sv */
// Port-level checker for the text console writer, bound to the top level below.
// Depends on tcw_pkg and on the ports of text_console_writer_core.
module tcw_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input logic                            done,
	input logic [tcw_pkg::CURSOR_O_W-1:0]  cursor,
	input logic [tcw_pkg::CELL_W-1:0]      read_data,
	input logic                            scrolled
);

	localparam int CELLS = COLUMNS * ROWS;

	// An accepted transaction keeps the block busy in the following cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("block not busy after an accepted transaction");

	// The result strobe comes only once the block is ready again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// One transaction gives one result, so the strobe never repeats at once.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	// Only a write can scroll, and a write returns no cell data.
	a_scroll_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && scrolled) |-> (read_data == '0))
		else $error("scrolled result carries read data");

	// The reported cursor always lies inside the store.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(cursor) < 32'(CELLS) || CELLS > 2047))
		else $error("cursor beyond the store");

endmodule

bind text_console_writer_core tcw_checker #(
	.COLUMNS (COLUMNS),
	.ROWS    (ROWS)
) u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cursor    (cursor),
	.read_data (read_data),
	.scrolled  (scrolled)
);

/* tb/text_console_checker.sv */
`timescale 1ns / 100ps
// Checker for the text console writer: follows attribute writes and accepted commands,
// keeps its own copy of the cell store and cursor, and compares every done strobe.
// Depends on tcw_pkg; instantiated by tb_text_console_writer_core beside the block.
module text_console_checker #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            attribute_we,
	input  logic [tcw_pkg::ATTR_W-1:0]      attribute,
	input  logic                            start,
	input  logic                            busy,
	input  logic [tcw_pkg::OP_W-1:0]        op,
	input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
	input  logic [tcw_pkg::ADDR_IN_W-1:0]   cell_address,
	input  logic                            done,
	input  logic [tcw_pkg::CURSOR_O_W-1:0]  cursor,
	input  logic [tcw_pkg::CELL_W-1:0]      read_data,
	input  logic                            scrolled,
	input  logic                            wrap_up,
	output int                              fail_count,
	output int                              outstanding,
	output int                              compared,
	output int                              scroll_count
);
	import tcw_pkg::*;

	localparam int CELLS      = ROWS * COLUMNS;
	localparam int TAB_SPACES = 4;

	typedef struct packed {
		logic [CURSOR_O_W-1:0] cursor;
		logic [CELL_W-1:0]     read_data;
		logic                  scrolled;
	} console_reply_t;

	logic [CELL_W-1:0] screen [CELLS];
	int unsigned       cur_pos;
	logic [ATTR_W-1:0] colour;
	logic              scroll_hit;
	logic              wrapped;
	console_reply_t    replies_due [$];

	function automatic logic [CELL_W-1:0] blank_cell();
		return {colour, BLANK_CHAR};
	endfunction

	// Move every row up by one and blank the bottom row with the current colour.
	function automatic void scroll_screen();
		int i;
		for (i = 0; i < CELLS - COLUMNS; i++)
			screen[i] = screen[i + COLUMNS];
		for (i = CELLS - COLUMNS; i < CELLS; i++)
			screen[i] = blank_cell();
	endfunction

	function automatic void wrap_past_end();
		if (cur_pos >= CELLS) begin
			cur_pos    = cur_pos - COLUMNS;
			scroll_screen();
			scroll_hit = 1'b1;
		end
	endfunction

	function automatic void put_char(logic [CHAR_W-1:0] ch);
		if (cur_pos < CELLS)
			screen[cur_pos] = {colour, ch};
		cur_pos = cur_pos + 1;
		wrap_past_end();
	endfunction

	function automatic void type_char(logic [CHAR_W-1:0] ch);
		int k;
		if (ch == CH_NEWLINE) begin
			cur_pos = cur_pos - (cur_pos % COLUMNS) + COLUMNS;
			wrap_past_end();
		end else if (ch == CH_TAB) begin
			// Each of the spaces may push the cursor off the end on its own.
			for (k = 0; k < TAB_SPACES; k++)
				put_char(BLANK_CHAR);
		end else if (ch == CH_BACKSPACE) begin
			if (cur_pos > 0) begin
				cur_pos = cur_pos - 1;
				if (cur_pos < CELLS)
					screen[cur_pos] = blank_cell();
			end
		end else begin
			put_char(ch);
		end
	endfunction

	function automatic console_reply_t step_console(logic [OP_W-1:0] code,
			logic [CHAR_W-1:0] ch, logic [ADDR_IN_W-1:0] addr);
		console_reply_t r;
		int k;
		scroll_hit  = 1'b0;
		r.read_data = '0;
		case (code)
			OP_WRITE: begin
				type_char(ch);
			end
			OP_CLEAR: begin
				for (k = 0; k < CELLS; k++)
					screen[k] = blank_cell();
				cur_pos = 0;
			end
			OP_READ: begin
				if (addr < CELLS)
					r.read_data = screen[addr];
			end
			default: begin
			end
		endcase
		r.cursor   = CURSOR_O_W'(cur_pos);
		r.scrolled = scroll_hit;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		console_reply_t want;
		int i;
		if (!arst_n) begin
			colour  = ATTR_RESET;
			cur_pos = 0;
			wrapped = 1'b0;
			for (i = 0; i < CELLS; i++)
				screen[i] = RESET_BLANK;
			replies_due.delete();
			outstanding = 0;
		end else begin
			if (attribute_we)
				colour = attribute;
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("done strobe with no transaction outstanding (cursor %0d)", cursor);
					fail_count++;
				end else begin
					want = replies_due.pop_front();
					compared++;
					if (want.scrolled)
						scroll_count++;
					if (cursor !== want.cursor) begin
						$error("cursor: expected %0d, got %0d", want.cursor, cursor);
						fail_count++;
					end
					if (read_data !== want.read_data) begin
						$error("read_data: expected 0x%04h, got 0x%04h", want.read_data,
							read_data);
						fail_count++;
					end
					if (scrolled !== want.scrolled) begin
						$error("scrolled: expected %0b, got %0b", want.scrolled, scrolled);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				replies_due.push_back(step_console(op, char_code, cell_address));
			if (wrap_up && !wrapped) begin
				wrapped = 1'b1;
				if (replies_due.size() != 0) begin
					$error("%0d transactions never produced a done strobe", replies_due.size());
					fail_count += replies_due.size();
				end
			end
			outstanding = replies_due.size();
		end
	end

endmodule

/* tb/tb_text_console_writer_core.sv */
`timescale 1ns / 100ps
// Top of the text console writer testbench: clock, reset, command stimulus and verdict.
// Depends on tcw_pkg, text_console_writer_core and text_console_checker.
module tb_text_console_writer_core;
	import tcw_pkg::*;

	localparam int COLUMNS = COLUMNS_DEF;
	localparam int ROWS    = ROWS_DEF;
	localparam int CELLS   = ROWS * COLUMNS;

	// The op field has one code the block does not define; it must leave everything alone.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int PHASES          = 5;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int ADDR_MAX        = (1 << ADDR_IN_W) - 1;

	// The slowest command is a tab or newline that scrolls and copies the whole store. Even if
	// every transaction took that long, waited out a long idle gap and followed a clear,
	// the run would stay well below this limit.
	localparam int TIMEOUT_CYCLES = 12_000_000;
	localparam int DRAIN_LIMIT    = 8 * CELLS + 1000;
	localparam int TAIL_CYCLES    = 2 * CELLS + 64;

	logic                  clk;
	logic                  arst_n;
	logic                  attribute_we;
	logic [ATTR_W-1:0]     attribute;
	logic                  start;
	logic                  busy;
	logic [OP_W-1:0]       op;
	logic [CHAR_W-1:0]     char_code;
	logic [ADDR_IN_W-1:0]  cell_address;
	logic                  done;
	logic [CURSOR_O_W-1:0] cursor;
	logic [CELL_W-1:0]     read_data;
	logic                  scrolled;
	logic                  wrap_up;

	int fail_count;
	int outstanding;
	int compared;
	int scroll_count;
	int cycle_count;
	int idle_pct;
	int sent_ops [4];

	text_console_writer_core #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.attribute_we(attribute_we),
		.attribute   (attribute),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.char_code   (char_code),
		.cell_address(cell_address),
		.done        (done),
		.cursor      (cursor),
		.read_data   (read_data),
		.scrolled    (scrolled)
	);

	text_console_checker #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) console_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.attribute_we(attribute_we),
		.attribute   (attribute),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.char_code   (char_code),
		.cell_address(cell_address),
		.done        (done),
		.cursor      (cursor),
		.read_data   (read_data),
		.scrolled    (scrolled),
		.wrap_up     (wrap_up),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.compared    (compared),
		.scroll_count(scroll_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// Anything that hangs the handshake ends up here rather than running forever.
	initial begin : watchdog
		wait (cycle_count >= TIMEOUT_CYCLES);
		$display("Some tests failed");
		$finish;
	end

	// Present one command from a falling edge and hold it until the block takes it. Busy
	// only moves on a rising edge, so once it reads low at a falling edge the transaction
	// is certain to go at the next rising edge.
	task automatic issue_cmd(logic [OP_W-1:0] code, logic [CHAR_W-1:0] ch,
			logic [ADDR_IN_W-1:0] addr);
		@(negedge clk);
		start        <= 1'b1;
		op           <= code;
		char_code    <= ch;
		cell_address <= addr;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		sent_ops[code]++;
	endtask

	// Random idle cycles between commands, as the current phase asks.
	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	// Stop sending and wait for every outstanding response and for the block to go idle.
	task automatic hold_until_drained();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0 || busy)
			@(negedge clk);
	endtask

	// The colour register is only written with the block idle, so no command in flight
	// can see a half-applied change.
	task automatic write_attribute(logic [ATTR_W-1:0] value);
		hold_until_drained();
		attribute_we <= 1'b1;
		attribute    <= value;
		@(negedge clk);
		attribute_we <= 1'b0;
	endtask

	// Mostly writes, a fifth of them newlines, so that the screen can fill and scroll;
	// tabs and backspaces come with them. Reads lean towards the bottom rows, where the
	// scrolled text ends up, and also cover addresses beyond the store.
	task automatic random_cmd();
		int pick;
		int sub;
		logic [CHAR_W-1:0]    ch;
		logic [ADDR_IN_W-1:0] addr;
		pick = $urandom_range(99);
		ch   = CHAR_W'($urandom_range(255));
		addr = ADDR_IN_W'($urandom_range(ADDR_MAX));
		if (pick < 78) begin
			sub = $urandom_range(99);
			if (sub < 20)
				ch = CH_NEWLINE;
			else if (sub < 30)
				ch = CH_TAB;
			else if (sub < 42)
				ch = CH_BACKSPACE;
			issue_cmd(OP_WRITE, ch, addr);
		end else if (pick < 93) begin
			if ($urandom_range(99) < 30)
				addr = ADDR_IN_W'($urandom_range(CELLS - 1, CELLS - 2 * COLUMNS));
			issue_cmd(OP_READ, ch, addr);
		end else if (pick < 96) begin
			issue_cmd(OP_CLEAR, ch, addr);
		end else begin
			issue_cmd(OP_UNUSED, ch, addr);
		end
	endtask

	initial begin : stimulus
		logic [ATTR_W-1:0] phase_attr [PHASES];
		int phase_idle [PHASES];
		int p;
		int n;
		int drain;

		arst_n       = 1'b0;
		attribute_we = 1'b0;
		attribute    = ATTR_RESET;
		start        = 1'b0;
		op           = OP_WRITE;
		char_code    = '0;
		cell_address = '0;
		wrap_up      = 1'b0;
		idle_pct     = 0;

		// The phases swing the colour byte between its extremes and random values, and
		// cover no idling, heavy idling and light idling on the command side. The
		// receiver takes every done strobe, so there is nothing to stall on that side.
		phase_attr[0] = 8'h00;
		phase_attr[1] = 8'hFF;
		phase_attr[2] = ATTR_W'($urandom_range(255));
		phase_attr[3] = ATTR_W'($urandom_range(255));
		phase_attr[4] = 8'hA5;
		phase_idle    = '{0, 56, 0, 23, 56};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed commands under the reset colour. The block is still clearing the store
		// after reset, which the first command simply waits out.
		issue_cmd(OP_WRITE, CH_BACKSPACE, '0);          // backspace with the cursor at zero
		issue_cmd(OP_WRITE, 8'h41, '0);
		issue_cmd(OP_WRITE, 8'h00, '0);
		issue_cmd(OP_WRITE, 8'hFF, 11'h7FF);
		issue_cmd(OP_WRITE, CH_TAB, '0);
		issue_cmd(OP_WRITE, CH_BACKSPACE, '0);          // blanks the last tab space
		issue_cmd(OP_WRITE, CH_NEWLINE, '0);
		issue_cmd(OP_WRITE, 8'h7E, '0);
		issue_cmd(OP_READ, 8'hFF, 11'd0);
		issue_cmd(OP_READ, 8'h00, 11'd1);
		issue_cmd(OP_READ, 8'h00, 11'd3);
		issue_cmd(OP_READ, 8'h00, 11'd80);
		issue_cmd(OP_READ, 8'h00, 11'(CELLS - 1));      // untouched, still the reset blank
		issue_cmd(OP_READ, 8'h00, 11'(CELLS));          // just past the store
		issue_cmd(OP_READ, 8'h00, 11'h7FF);
		issue_cmd(OP_UNUSED, 8'h41, 11'd5);
		issue_cmd(OP_CLEAR, 8'hFF, 11'h7FF);
		issue_cmd(OP_READ, 8'h00, 11'd0);
		issue_cmd(OP_READ, 8'h00, 11'(CELLS - 1));
		issue_cmd(OP_WRITE, CH_BACKSPACE, '0);

		// Random commands. A newline on the bottom row, scrolling from a tab and
		// backspacing over scrolled text all come up many times once the screen is full.
		for (p = 0; p < PHASES; p++) begin
			write_attribute(phase_attr[p]);
			idle_pct = phase_idle[p];
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(99) < 2)
					hold_until_drained();
				idle_gap();
				random_cmd();
			end
		end

		@(negedge clk);
		start <= 1'b0;
		drain = 0;
		while (outstanding != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		// Stray done strobes after the last response would still be caught here.
		repeat (TAIL_CYCLES) @(negedge clk);
		wrap_up <= 1'b1;
		repeat (2) @(negedge clk);

		$display("Sent %0d commands: %0d writes, %0d clears, %0d reads, %0d unused op.",
			sent_ops[0] + sent_ops[1] + sent_ops[2] + sent_ops[3],
			sent_ops[OP_WRITE], sent_ops[OP_CLEAR], sent_ops[OP_READ], sent_ops[OP_UNUSED]);
		$display("Compared %0d responses, %0d of them with a scroll, over %0d colour settings.",
			compared, scroll_count, PHASES + 1);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* sim.f */
hdl/tcw_pkg.sv
hdl/tcw_cursor.sv
hdl/text_console_writer_core.sv
hdl/tcw_checker.sv
tb/text_console_checker.sv
tb/tb_text_console_writer_core.sv
